// ----- hdl/sra_pkg.sv -----
// Shared widths and the in-word first-set-bit search for the selective-repeat acknowledgement unit.
package sra_pkg;

    localparam int SEQ_W      = 16;
    localparam int CNT_W      = 11;
    localparam int ACK_W      = 11;
    localparam int WORD_W     = 32;
    localparam int WORD_IDX_W = 5;

    // Returns {found, position} of the lowest set bit of the word.
    function automatic logic [WORD_IDX_W:0] find_first(input logic [WORD_W-1:0] v);
        logic [WORD_IDX_W:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = {1'b1, WORD_IDX_W'(i)};
            end
        end
        return r;
    endfunction

endpackage

// ----- hdl/selective_repeat_receiver_ack_unit.sv -----
// Receiver side of a selective-repeat transfer: received bitmap and cumulative acknowledgement.
// A packet is taken when start is high and busy is low. A packet with checksum_ok low is dropped
// in that cycle and the block stays free. An out-of-range packet skips the bitmap and goes to the
// finish state, which registers its acknowledgement strobe. A packet in range is marked in a
// bitmap memory of ceil(MAX_PACKETS/32) words with one read and one write port; if it fills the
// expected number, the gap search reads one word per cycle. When a packet completes the transfer
// the bitmap is cleared one word per cycle, and the same clearing pass runs after reset.
// result_valid marks each acknowledgement for one cycle only and cannot be held off, so the
// receiver must take it then. The packet count register is written through cfg_valid and
// cfg_ready is always high; write it while busy is low, since a write while busy applies to
// the request in progress.
module selective_repeat_receiver_ack_unit #(
    parameter int MAX_PACKETS = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [sra_pkg::SEQ_W-1:0]  seq_number,
    input  logic                       checksum_ok,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [sra_pkg::CNT_W-1:0]  cfg_data,
    output logic                       result_valid,
    output logic [sra_pkg::ACK_W-1:0]  ack_number,
    output logic                       transfer_done,
    output logic                       out_of_range
);
    import sra_pkg::*;

    localparam int DEPTH  = (MAX_PACKETS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EXP_W  = $clog2(MAX_PACKETS + 2);
    localparam int CMP_W  = ((EXP_W > SEQ_W) ? EXP_W : SEQ_W) + 1;
    localparam int NUM_W  = ADDR_W + WORD_IDX_W + 1;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MODIFY = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam logic [EXP_W-1:0]  END_NUM   = EXP_W'(MAX_PACKETS + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [2:0]        state_reg, state_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic              oor_reg, oor_next;
    logic [EXP_W-1:0]  exp_reg, exp_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              valid_reg, valid_next;
    logic [ACK_W-1:0]  ack_reg, ack_next;
    logic              done_reg, done_next;
    logic              oflag_reg, oflag_next;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    logic                  accept;
    logic                  in_oor;
    logic [SEQ_W-1:0]      in_m1;
    logic [SEQ_W-1:0]      seq_m1;
    logic [WORD_IDX_W-1:0] bit_pos;
    logic [ADDR_W-1:0]     word_a;
    logic [WORD_W-1:0]     merged;
    logic [WORD_W-1:0]     sel_mask;
    logic [WORD_IDX_W:0]   ff;
    logic [ADDR_W-1:0]     cur_word;
    logic [EXP_W-1:0]      found_num;
    logic                  last_word;
    logic                  done_now;

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = valid_reg;
    assign ack_number   = ack_reg;
    assign transfer_done = done_reg;
    assign out_of_range = oflag_reg;

    assign accept  = start && !busy;
    assign in_m1   = seq_number - 1'b1;
    assign in_oor  = (seq_number == '0) || (CMP_W'(seq_number) > CMP_W'(MAX_PACKETS));
    assign seq_m1  = seq_reg - 1'b1;
    assign bit_pos = seq_m1[WORD_IDX_W-1:0];
    assign word_a  = seq_m1[ADDR_W+WORD_IDX_W-1:WORD_IDX_W];
    assign merged  = rd_data_reg | (WORD_W'(1) << bit_pos);

    // In the modified word the search starts just above the packet's own bit.
    always_comb
    begin
        if (state_reg == ST_MODIFY)
        begin
            sel_mask = ~merged & ({WORD_W{1'b1}} << ({1'b0, bit_pos} + 6'd1));
            cur_word = word_a;
        end
        else
        begin
            sel_mask = ~rd_data_reg;
            cur_word = addr_reg;
        end
    end

    assign ff        = find_first(sel_mask);
    assign found_num = EXP_W'({cur_word, ff[WORD_IDX_W-1:0]} + NUM_W'(1));
    assign last_word = (cur_word == LAST_ADDR);
    assign done_now  = CMP_W'(exp_reg) >= (CMP_W'(count_reg) + CMP_W'(1));

    always_comb
    begin
        state_next = state_reg;
        seq_next   = seq_reg;
        oor_next   = oor_reg;
        exp_next   = exp_reg;
        addr_next  = addr_reg;
        count_next = cfg_valid ? cfg_data : count_reg;
        valid_next = 1'b0;
        ack_next   = ack_reg;
        done_next  = done_reg;
        oflag_next = oflag_reg;
        mem_we     = 1'b0;
        mem_waddr  = word_a;
        mem_wdata  = merged;
        mem_re     = 1'b0;
        mem_raddr  = ADDR_W'(cur_word + 1'b1);

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = '0;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept && checksum_ok)
                begin
                    seq_next = seq_number;
                    oor_next = in_oor;
                    if (in_oor)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = in_m1[ADDR_W+WORD_IDX_W-1:WORD_IDX_W];
                        state_next = ST_MODIFY;
                    end
                end
            end
            ST_MODIFY:
            begin
                mem_we = 1'b1;
                if (CMP_W'(seq_reg) == CMP_W'(exp_reg))
                begin
                    if (ff[WORD_IDX_W])
                    begin
                        exp_next   = found_num;
                        state_next = ST_FINISH;
                    end
                    else if (last_word)
                    begin
                        exp_next   = END_NUM;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        addr_next  = ADDR_W'(word_a + 1'b1);
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (ff[WORD_IDX_W])
                begin
                    exp_next   = found_num;
                    state_next = ST_FINISH;
                end
                else if (last_word)
                begin
                    exp_next   = END_NUM;
                    state_next = ST_FINISH;
                end
                else
                begin
                    mem_re    = 1'b1;
                    addr_next = ADDR_W'(addr_reg + 1'b1);
                end
            end
            ST_FINISH:
            begin
                valid_next = 1'b1;
                ack_next   = ACK_W'(exp_reg);
                done_next  = done_now;
                oflag_next = oor_reg;
                if (done_now)
                begin
                    exp_next   = EXP_W'(1);
                    addr_next  = '0;
                    state_next = ST_CLEAR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            exp_reg   <= EXP_W'(1);
            addr_reg  <= '0;
            count_reg <= CNT_W'(1);
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            exp_reg   <= exp_next;
            addr_reg  <= addr_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg   <= seq_next;
        oor_reg   <= oor_next;
        ack_reg   <= ack_next;
        done_reg  <= done_next;
        oflag_reg <= oflag_next;
    end

    // Bitmap memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

// ----- hdl/sra_checker.sv -----
// Port-level checks for the selective-repeat acknowledgement unit, bound to the top level.
module sra_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      checksum_ok,
    input logic                      result_valid,
    input logic [sra_pkg::ACK_W-1:0] ack_number
);
    import sra_pkg::*;

    // A request is taken only while free, and no acknowledgement can follow it at once.
    a_no_strobe_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !result_valid)
        else $error("result strobe directly after an accepted request");

    // A good packet always occupies the block before its acknowledgement.
    a_good_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && checksum_ok) |=> busy)
        else $error("good packet accepted without going busy");

    // Each acknowledgement is a single-cycle strobe.
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held longer than one cycle");

    // An acknowledgement follows a cycle spent busy.
    a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without preceding work");

    // The acknowledged number never goes undefined.
    a_ack_known: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !$isunknown(ack_number))
        else $error("acknowledgement number unknown");

endmodule

bind selective_repeat_receiver_ack_unit sra_checker u_sra_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .checksum_ok  (checksum_ok),
    .result_valid (result_valid),
    .ack_number   (ack_number)
);

// ----- test/sra_ack_checker.sv -----
// Checker for the selective-repeat acknowledgement unit: predicts each acknowledgement and compares.
`timescale 1ns / 100ps

module sra_ack_checker #(
    parameter int MAX_PACKETS = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [sra_pkg::SEQ_W-1:0]  seq_number,
    input  logic                       checksum_ok,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [sra_pkg::CNT_W-1:0]  cfg_data,
    input  logic                       result_valid,
    input  logic [sra_pkg::ACK_W-1:0]  ack_number,
    input  logic                       transfer_done,
    input  logic                       out_of_range,
    output int                         fail_count,
    output int                         pending,
    output int                         ack_count,
    output int                         done_count,
    output int                         drop_count
);

    typedef struct packed {
        logic [sra_pkg::ACK_W-1:0] ack;
        logic                      done;
        logic                      oor;
    } ack_rec_t;

    ack_rec_t                  pending_acks[$];
    logic [MAX_PACKETS-1:0]    seen_map;
    int unsigned               next_expected;
    logic [sra_pkg::CNT_W-1:0] pkt_count;

    // Works out the acknowledgement for one packet request and updates the bitmap.
    task automatic predict_ack(input logic [sra_pkg::SEQ_W-1:0] s, input logic good);
        ack_rec_t    rec;
        int unsigned n;
        logic        oor;
        if (!good)
        begin
            drop_count++;
            return;
        end
        oor = (s == 0) || (int'(s) > MAX_PACKETS);
        if (!oor)
        begin
            seen_map[s - 1] = 1'b1;
            if (int'(s) == next_expected)
            begin
                n = int'(s) + 1;
                while (n <= MAX_PACKETS && seen_map[n - 1])
                begin
                    n++;
                end
                next_expected = n;
            end
        end
        rec.done = (next_expected >= int'(pkt_count) + 1);
        rec.ack  = sra_pkg::ACK_W'(next_expected);
        rec.oor  = oor;
        pending_acks.push_back(rec);
        if (rec.done)
        begin
            seen_map      = '0;
            next_expected = 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ack_rec_t want;
        if (!rst_n)
        begin
            pending_acks.delete();
            seen_map      = '0;
            next_expected = 1;
            pkt_count     = sra_pkg::CNT_W'(1);
            fail_count    = 0;
            pending       = 0;
            ack_count     = 0;
            done_count    = 0;
            drop_count    = 0;
        end
        else
        begin
            // A strobe always belongs to a request taken at an earlier edge.
            if (result_valid === 1'b1)
            begin
                if (pending_acks.size() == 0)
                begin
                    $error("acknowledgement with none expected: ack_number %0d", ack_number);
                    fail_count++;
                end
                else
                begin
                    want = pending_acks.pop_front();
                    ack_count++;
                    if (want.done)
                    begin
                        done_count++;
                    end
                    if (ack_number !== want.ack)
                    begin
                        $error("ack_number: expected %0d, actual %0d", want.ack, ack_number);
                        fail_count++;
                    end
                    if (transfer_done !== want.done)
                    begin
                        $error("transfer_done: expected %0d, actual %0d", want.done,
                               transfer_done);
                        fail_count++;
                    end
                    if (out_of_range !== want.oor)
                    begin
                        $error("out_of_range: expected %0d, actual %0d", want.oor,
                               out_of_range);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                pkt_count = cfg_data;
            end
            if (start && !busy)
            begin
                predict_ack(seq_number, checksum_ok);
            end
            pending = pending_acks.size();
        end
    end

endmodule

// ----- test/tb_selective_repeat_receiver_ack_unit.sv -----
// Testbench top for the selective-repeat acknowledgement unit: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb_selective_repeat_receiver_ack_unit;

    localparam int MAX_PKTS    = 1024;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 80;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [sra_pkg::SEQ_W-1:0]  seq_number;
    logic                       checksum_ok;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [sra_pkg::CNT_W-1:0]  cfg_data;
    logic                       result_valid;
    logic [sra_pkg::ACK_W-1:0]  ack_number;
    logic                       transfer_done;
    logic                       out_of_range;

    int fail_count;
    int pending;
    int ack_count;
    int done_count;
    int drop_count;
    int stall_cycles;
    int settings_written;
    bit idling;

    selective_repeat_receiver_ack_unit #(
        .MAX_PACKETS(MAX_PKTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .seq_number   (seq_number),
        .checksum_ok  (checksum_ok),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .ack_number   (ack_number),
        .transfer_done(transfer_done),
        .out_of_range (out_of_range)
    );

    sra_ack_checker #(
        .MAX_PACKETS(MAX_PKTS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .seq_number   (seq_number),
        .checksum_ok  (checksum_ok),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .ack_number   (ack_number),
        .transfer_done(transfer_done),
        .out_of_range (out_of_range),
        .fail_count   (fail_count),
        .pending      (pending),
        .ack_count    (ack_count),
        .done_count   (done_count),
        .drop_count   (drop_count)
    );

    always #5 clk = ~clk;

    // Ends the run when nothing at all is taken for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
        else
        begin
            stall_cycles <= 0;
        end
    end

    function automatic logic [sra_pkg::SEQ_W-1:0] oor_number();
        if ($urandom_range(0, 1) == 0)
        begin
            return '0;
        end
        return sra_pkg::SEQ_W'($urandom_range(MAX_PKTS + 1, 65535));
    endfunction

    // Start stays high from request to request unless an idle burst or a count write intervenes.
    task automatic send_packet(input logic [sra_pkg::SEQ_W-1:0] s, input logic good);
        int gap;
        @(negedge clk);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 13);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        seq_number  <= s;
        checksum_ok <= good;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    // The count register is only changed once every acknowledgement is in and the block is quiet.
    task automatic write_count(input logic [sra_pkg::CNT_W-1:0] v);
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_written++;
    endtask

    // Sends the numbers 1..n in shuffled order with noise mixed in; cut stops part way.
    task automatic run_transfer(input int n, input bit cut);
        int order[];
        int j;
        int tmp;
        int roll;
        int last;
        order = new[n];
        for (int i = 0; i < n; i++)
        begin
            order[i] = i + 1;
        end
        for (int i = n - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        last = cut ? $urandom_range(0, n - 1) : n;
        for (int i = 0; i < last; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                send_packet(sra_pkg::SEQ_W'($urandom_range(0, 65535)), 1'b0);
            end
            else if (roll < 6)
            begin
                send_packet(sra_pkg::SEQ_W'(order[i]), 1'b0);
            end
            else if (roll < 10)
            begin
                send_packet(oor_number(), 1'b1);
            end
            else if (roll < 15 && i > 0)
            begin
                send_packet(sra_pkg::SEQ_W'(order[$urandom_range(0, i - 1)]), 1'b1);
            end
            send_packet(sra_pkg::SEQ_W'(order[i]), 1'b1);
        end
    endtask

    task automatic run_noise(input int n);
        int roll;
        logic [sra_pkg::SEQ_W-1:0] s;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 4)
            begin
                s = sra_pkg::SEQ_W'($urandom_range(1, MAX_PKTS));
            end
            else if (roll < 7)
            begin
                s = sra_pkg::SEQ_W'($urandom_range(1, 16));
            end
            else
            begin
                s = sra_pkg::SEQ_W'($urandom_range(0, 65535));
            end
            send_packet(s, $urandom_range(0, 3) != 0);
        end
    endtask

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        start            = 1'b0;
        seq_number       = '0;
        checksum_ok      = 1'b0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        settings_written = 0;
        idling           = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Count of one from reset: out of order first, then the number that completes it.
        send_packet(16'd5, 1'b1);
        send_packet(16'd1, 1'b1);
        send_packet(16'd0, 1'b1);
        send_packet(16'hFFFF, 1'b1);
        send_packet(sra_pkg::SEQ_W'(MAX_PKTS + 1), 1'b1);
        send_packet(sra_pkg::SEQ_W'(MAX_PKTS), 1'b1);
        send_packet(16'd3, 1'b0);
        send_packet(16'd1, 1'b0);
        // A count of zero completes on every good packet.
        write_count(11'd0);
        send_packet(16'd7, 1'b1);
        send_packet(16'd0, 1'b1);
        // Gap filling with a duplicate and a dropped packet.
        write_count(11'd4);
        send_packet(16'd2, 1'b1);
        send_packet(16'd4, 1'b1);
        send_packet(16'd2, 1'b1);
        send_packet(16'd3, 1'b1);
        send_packet(16'd1, 1'b0);
        send_packet(16'd1, 1'b1);
        // Packets beyond the count push the expected number past it.
        write_count(11'd3);
        send_packet(16'd1, 1'b1);
        send_packet(16'd2, 1'b1);
        send_packet(16'd4, 1'b1);
        send_packet(16'd5, 1'b1);
        send_packet(16'd3, 1'b1);
        // A count above the bitmap size never completes.
        write_count(11'h7FF);
        send_packet(16'd1, 1'b1);
        send_packet(16'hFFFF, 1'b0);
        send_packet(sra_pkg::SEQ_W'(MAX_PKTS), 1'b1);

        write_count(11'd3);
        repeat (4) run_transfer(3, 1'b0);
        write_count(11'd17);
        run_transfer(17, 1'b0);
        run_transfer(17, 1'b1);
        write_count(11'h7FF);
        run_noise(40);
        write_count(11'd64);
        run_transfer(64, 1'b0);
        run_transfer(64, 1'b0);
        write_count(11'd9);
        repeat (4) run_transfer(9, 1'b0);
        write_count(11'd60);
        run_transfer(60, 1'b0);
        write_count(11'd40);
        run_transfer(40, 1'b1);
        run_transfer(40, 1'b0);
        write_count(11'd1);
        repeat (10) run_transfer(1, 1'b0);
        write_count(11'd0);
        run_noise(15);
        write_count(11'd100);
        run_transfer(100, 1'b0);
        write_count(11'd5);
        repeat (4) run_transfer(5, 1'b0);
        write_count(11'(MAX_PKTS + 1));
        run_noise(40);
        write_count(11'd33);
        run_transfer(33, 1'b1);
        run_transfer(33, 1'b0);
        idling = 1'b0;
        write_count(11'd12);
        repeat (3) run_transfer(12, 1'b0);
        write_count(11'd6);
        repeat (3) run_transfer(6, 1'b0);

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (100) @(negedge clk);

        $display("Checked %0d acknowledgements, %0d of them completing a transfer, and %0d dropped",
                 ack_count, done_count, drop_count);
        $display("packets over %0d packet-count settings, from zero to the all-ones value.",
                 settings_written);
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
